@@ sv/rlrpu_pkg.sv @@
// Shared types and constants of the run-length projective remap unit.
// Holds the word structs, configuration bundle, datapath op codes and status.
// No dependencies.
package rlrpu_pkg;

	localparam int RUN_W  = 25;
	localparam int HGT_W  = 13;
	localparam int HOLD_W = 41;
	localparam int COEF_W = 64;
	localparam int MUL_W  = 90;
	localparam int NUM_W  = 91;
	localparam int REM_W  = 80;
	localparam int CNT_W  = 7;

	localparam logic [HGT_W-1:0]  MAX_HEIGHT = 13'd4096;
	localparam logic [HGT_W-1:0]  MAX_WIDTH  = 13'd4096;
	localparam logic [RUN_W-1:0]  RUN_MAX    = '1;
	localparam logic [HOLD_W-1:0] HOLD_CAP   = 41'h100_0000_0000;

	// register indexes of the configuration port
	localparam logic [2:0] REG_A0 = 3'd0;
	localparam logic [2:0] REG_A1 = 3'd1;
	localparam logic [2:0] REG_A2 = 3'd2;
	localparam logic [2:0] REG_A3 = 3'd3;
	localparam logic [2:0] REG_A4 = 3'd4;
	localparam logic [2:0] REG_A5 = 3'd5;
	localparam logic [2:0] REG_SRC_H = 3'd6;
	localparam logic [2:0] REG_OUT_H = 3'd7;

	typedef struct packed {
		logic [RUN_W-1:0] run_length;
		logic             final_item;
	} item_t;

	typedef struct packed {
		logic [RUN_W-1:0] out_run;
		logic             run_value;
		logic             last_run;
	} result_t;

	typedef struct packed {
		logic [5:0][COEF_W-1:0] coef;
		logic [HGT_W-1:0]       src_height;
		logic [HGT_W-1:0]       out_height;
	} cfg_t;

	typedef logic [4:0] op_t;

	localparam op_t OP_NOP            = 5'd0;
	localparam op_t OP_LOAD           = 5'd1;
	localparam op_t OP_ZPOS           = 5'd2;
	localparam op_t OP_FINPOS         = 5'd3;
	localparam op_t OP_ONEPOS         = 5'd4;
	localparam op_t OP_DIV_R          = 5'd5;
	localparam op_t OP_DIV_END        = 5'd6;
	localparam op_t OP_DIV_W          = 5'd7;
	localparam op_t OP_GET_XS         = 5'd8;
	localparam op_t OP_GET_YE         = 5'd9;
	localparam op_t OP_GET_W          = 5'd10;
	localparam op_t OP_MUL_SLOPE      = 5'd11;
	localparam op_t OP_MUL_OFFS       = 5'd12;
	localparam op_t OP_MUL_N          = 5'd13;
	localparam op_t OP_MUL_D          = 5'd14;
	localparam op_t OP_PUT_SLOPE      = 5'd15;
	localparam op_t OP_PUT_OFFS       = 5'd16;
	localparam op_t OP_PUT_N          = 5'd17;
	localparam op_t OP_PUT_D          = 5'd18;
	localparam op_t OP_MAP_START      = 5'd19;
	localparam op_t OP_PUT_ROW        = 5'd20;
	localparam op_t OP_ORDER          = 5'd21;
	localparam op_t OP_COMMIT         = 5'd22;
	localparam op_t OP_FIN_CZ         = 5'd23;
	localparam op_t OP_MERGE          = 5'd24;
	localparam op_t OP_EMIT_ZERO_NEW  = 5'd25;
	localparam op_t OP_EMIT_HELD      = 5'd26;
	localparam op_t OP_EMIT_HELD_FIN  = 5'd27;
	localparam op_t OP_EMIT_PEND_LAST = 5'd28;
	localparam op_t OP_CLEAR          = 5'd29;

	typedef struct packed {
		op_t  op;
		logic sel;
	} dp_cmd_t;

	typedef struct packed {
		logic fin;
		logic expect_ones;
		logic busy;
		logic skip;
		logic no_zero;
		logic held_zero;
		logic pend_zero;
	} dp_stat_t;

endpackage

@@ sv/rle_run_projective_remap_unit.sv @@
// Run-length projective remap unit: top level with register port and output register.
// Instantiates rlrpu_ctrl and rlrpu_dp; depends on rlrpu_pkg.
//
// Takes a column-major mask as alternating zero/one run lengths and remaps every ones run
// through a per-column rational function, giving output runs for a mask of out_height rows.
// A zeros word only advances the position. A ones word runs two 25/26-step height divisions
// and two 91-step row divisions on one shared restoring divider (one quotient bit per cycle)
// and six 13-step products on one serial multiplier, then waits on the output register for
// any result words. The final word runs a width division on the same divider, then waits
// on the output register for its result words. One word is in work at a time; the output
// register lets the next word be taken while a result waits.
module rle_run_projective_remap_unit import rlrpu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_t        item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_t      result
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     emit;
	result_t  emit_word;
	logic     out_free;
	logic     result_valid_q;
	result_t  result_q;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef       <= {64'h0000_0001_0000_0000, 320'd0};
			cfg_q.src_height <= 13'd1;
			cfg_q.out_height <= 13'd1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SRC_H: cfg_q.src_height <= pwdata[HGT_W-1:0];
				REG_OUT_H: cfg_q.out_height <= pwdata[HGT_W-1:0];
				default:   cfg_q.coef[reg_idx] <= pwdata;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_SRC_H: prdata = 64'(cfg_q.src_height);
			REG_OUT_H: prdata = 64'(cfg_q.out_height);
			default:   prdata = cfg_q.coef[reg_idx];
		endcase
	end

	// output register: load on issue, drop when taken
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (emit)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_q <= emit_word;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	rlrpu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.out_free   (out_free),
		.stat       (stat),
		.cmd        (cmd)
	);

	rlrpu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg       (cfg_q),
		.stat      (stat),
		.emit      (emit),
		.emit_word (emit_word)
	);

endmodule

@@ sv/rlrpu_dp.sv @@
// Datapath of the run-length projective remap unit: run state, serial
// multiplier, shared restoring divider, row mapping and word forming.
// Depends on rlrpu_pkg.
module rlrpu_dp import rlrpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  item_t    item,
	input  cfg_t     cfg,
	output dp_stat_t stat,
	output logic     emit,
	output result_t  emit_word
);

	// run state
	logic [RUN_W-1:0]  pos_q, len_q, r_q;
	logic              expect_q, fin_q, prev_valid_q;
	logic [HGT_W-1:0]  prev_col_q, prev_row_q;
	logic [HOLD_W-1:0] pend_q, held_q;
	logic [RUN_W:0]    end_q;
	logic              end_zero_q;

	// per-run working registers
	logic [HGT_W-1:0]        x_q, ys_q, ye_q, yeo_q, no_q;
	logic [1:0][HGT_W-1:0]   row_q;
	logic [RUN_W-1:0]        nz_q;
	logic                    skip_q;
	logic signed [MUL_W-1:0] slope_q, offs_q, n_q, d_q;

	// serial multiplier
	logic signed [MUL_W-1:0] acc_q, mcand_q;
	logic [HGT_W-1:0]        mpl_q;
	logic [3:0]              mcnt_q;

	// restoring divider
	logic [NUM_W-1:0] num_q, quo_q;
	logic [REM_W-1:0] den_q, rem_q;
	logic [CNT_W-1:0] dcnt_q;

	logic [HGT_W-1:0] h, oh;
	logic [RUN_W:0]   pos_sum;
	logic [RUN_W-1:0] pos_sat;
	logic [RUN_W:0]   end_m1;
	logic [REM_W-1:0] rem_sh, rem_nx;
	logic             rem_ge;
	logic [HGT_W-1:0] y_sel, x_clip, row_new, yso, yeo;
	logic [MUL_W-1:0] n_mag, d_mag;
	logic [NUM_W-1:0] num_ld;
	logic [REM_W-1:0] den_ld;
	logic             n_pos, d_zero, sgn_diff, q_big;
	logic signed [13:0] pc;
	logic [HGT_W-1:0]   prow;
	logic signed [14:0] cdiff;
	logic signed [28:0] cprod;
	logic signed [29:0] nz_full, no_full, cz_full;
	logic [RUN_W-1:0]   cz_pos;
	logic [HOLD_W:0]    pend_nz, pend_cz, held_no;

	function automatic logic [HGT_W-1:0] clamp_h(input logic [HGT_W-1:0] v);
		if (v == '0)
			return 13'd1;
		return (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
	endfunction

	function automatic logic [HOLD_W-1:0] cap(input logic [HOLD_W:0] v);
		return (v > {1'b0, HOLD_CAP}) ? HOLD_CAP : v[HOLD_W-1:0];
	endfunction

	function automatic logic [RUN_W-1:0] sat_run(input logic [HOLD_W-1:0] v);
		return (v > HOLD_W'(RUN_MAX)) ? RUN_MAX : v[RUN_W-1:0];
	endfunction

	function automatic logic signed [MUL_W-1:0] sext(input logic [COEF_W-1:0] c);
		return {{(MUL_W-COEF_W){c[COEF_W-1]}}, c};
	endfunction

	// heights and position update
	assign h       = clamp_h(cfg.src_height);
	assign oh      = clamp_h(cfg.out_height);
	assign pos_sum = {1'b0, pos_q} + {1'b0, len_q};
	assign pos_sat = pos_sum[RUN_W] ? RUN_MAX : pos_sum[RUN_W-1:0];
	assign end_m1  = end_q - 26'd1;

	// one divider step
	assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign rem_ge = (rem_sh >= den_q);
	assign rem_nx = rem_ge ? (rem_sh - den_q) : rem_sh;

	assign y_sel  = cmd.sel ? ye_q : ys_q;
	assign x_clip = (quo_q[RUN_W-1:0] > RUN_W'(MAX_WIDTH)) ? MAX_WIDTH : quo_q[HGT_W-1:0];

	// rounded division operands: (2|n| + |d|) / (2|d|)
	assign n_mag  = n_q[MUL_W-1] ? MUL_W'(-n_q) : MUL_W'(n_q);
	assign d_mag  = d_q[MUL_W-1] ? MUL_W'(-d_q) : MUL_W'(d_q);
	assign num_ld = {n_mag, 1'b0} + {1'b0, d_mag};
	assign den_ld = {d_mag[REM_W-2:0], 1'b0};

	// mapped row from quotient or zero-denominator sign
	assign n_pos    = !n_q[MUL_W-1] && (n_q != '0);
	assign d_zero   = (d_q == '0);
	assign sgn_diff = n_q[MUL_W-1] != d_q[MUL_W-1];
	assign q_big    = (quo_q[NUM_W-1:HGT_W] != '0) || (quo_q[HGT_W-1:0] > oh);
	always_comb begin
		if (d_zero)
			row_new = n_pos ? oh : '0;
		else if (sgn_diff)
			row_new = '0;
		else
			row_new = q_big ? oh : quo_q[HGT_W-1:0];
	end

	// order ends and place the run against the previous one
	assign yso     = (row_q[0] > row_q[1]) ? row_q[1] : row_q[0];
	assign yeo     = (row_q[0] > row_q[1]) ? row_q[0] : row_q[1];
	assign pc      = prev_valid_q ? $signed({1'b0, prev_col_q}) : -14'sd1;
	assign prow    = prev_valid_q ? prev_row_q : oh;
	assign cdiff   = $signed({2'b0, x_q}) - $signed({pc[13], pc});
	assign cprod   = $signed({1'b0, oh}) * cdiff;
	assign nz_full = 30'(cprod) + $signed({17'b0, yso}) - $signed({17'b0, prow});
	assign no_full = $signed({17'b0, yeo}) - $signed({17'b0, yso})
		+ (nz_full[29] ? nz_full : 30'sd0);
	assign cz_full = 30'(cprod) - $signed({17'b0, prow});
	assign cz_pos  = cz_full[29] ? '0 : cz_full[RUN_W-1:0];
	assign pend_nz = {1'b0, pend_q} + 42'(nz_q);
	assign pend_cz = {1'b0, pend_q} + 42'(cz_pos);
	assign held_no = {1'b0, held_q} + 42'(no_q);

	// form the output word
	always_comb begin
		emit      = 1'b0;
		emit_word = '0;
		unique case (cmd.op)
			OP_EMIT_ZERO_NEW: begin
				emit      = 1'b1;
				emit_word = '{out_run: sat_run(pend_q), run_value: 1'b0, last_run: 1'b0};
			end
			OP_EMIT_HELD: begin
				emit      = 1'b1;
				emit_word = '{out_run: sat_run(held_q), run_value: 1'b1, last_run: 1'b0};
			end
			OP_EMIT_HELD_FIN: begin
				emit      = 1'b1;
				emit_word = '{out_run: sat_run(held_q), run_value: 1'b1,
					last_run: (pend_q == '0)};
			end
			OP_EMIT_PEND_LAST: begin
				emit      = 1'b1;
				emit_word = '{out_run: sat_run(pend_q), run_value: 1'b0, last_run: 1'b1};
			end
			default: begin
				emit      = 1'b0;
				emit_word = '0;
			end
		endcase
	end

	assign stat = '{fin: fin_q, expect_ones: expect_q, busy: (mcnt_q != '0) || (dcnt_q != '0),
		skip: skip_q, no_zero: (no_q == '0), held_zero: (held_q == '0),
		pend_zero: (pend_q == '0)};

	// control state: run position, phase, previous placement, held sums, unit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			expect_q     <= 1'b0;
			fin_q        <= 1'b0;
			prev_valid_q <= 1'b0;
			pend_q       <= '0;
			held_q       <= '0;
			mcnt_q       <= '0;
			dcnt_q       <= '0;
		end else begin
			if (mcnt_q != '0)
				mcnt_q <= mcnt_q - 4'd1;
			if (dcnt_q != '0)
				dcnt_q <= dcnt_q - 7'd1;
			unique case (cmd.op)
				OP_LOAD:   fin_q <= item.final_item;
				OP_ZPOS: begin
					pos_q    <= pos_sat;
					expect_q <= 1'b1;
				end
				OP_FINPOS: pos_q <= pos_sat;
				OP_ONEPOS: begin
					pos_q    <= pos_sat;
					expect_q <= 1'b0;
				end
				OP_DIV_R, OP_DIV_W: dcnt_q <= 7'd25;
				OP_DIV_END:         dcnt_q <= 7'd26;
				OP_MAP_START:       dcnt_q <= 7'd91;
				OP_MUL_SLOPE, OP_MUL_OFFS, OP_MUL_N, OP_MUL_D: mcnt_q <= 4'd13;
				OP_COMMIT: begin
					prev_valid_q <= 1'b1;
					pend_q       <= cap(pend_nz);
				end
				OP_FIN_CZ: pend_q <= cap(pend_cz);
				OP_MERGE:  held_q <= cap(held_no);
				OP_EMIT_ZERO_NEW: begin
					held_q <= HOLD_W'(no_q);
					pend_q <= '0;
				end
				OP_CLEAR: begin
					pos_q        <= '0;
					expect_q     <= 1'b0;
					prev_valid_q <= 1'b0;
					pend_q       <= '0;
					held_q       <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers and arithmetic units
	always_ff @(posedge clk) begin
		if (mcnt_q != '0) begin
			if (mpl_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mpl_q   <= mpl_q >> 1;
		end
		if (dcnt_q != '0) begin
			rem_q <= rem_nx;
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
		unique case (cmd.op)
			OP_LOAD: len_q <= item.run_length;
			OP_ONEPOS: begin
				r_q        <= pos_q;
				end_q      <= pos_sum;
				end_zero_q <= (pos_sum == '0);
			end
			OP_DIV_R, OP_DIV_W, OP_DIV_END, OP_MAP_START: begin
				rem_q <= '0;
				quo_q <= '0;
				if (cmd.op == OP_MAP_START) begin
					num_q <= num_ld;
					den_q <= den_ld;
				end else begin
					den_q <= REM_W'(h);
					if (cmd.op == OP_DIV_END)
						num_q <= {end_m1, 65'b0};
					else if (cmd.op == OP_DIV_R)
						num_q <= {r_q, 66'b0};
					else
						num_q <= {pos_q, 66'b0};
				end
			end
			OP_GET_XS: begin
				x_q  <= x_clip;
				ys_q <= rem_q[HGT_W-1:0];
			end
			OP_GET_YE: ye_q <= end_zero_q ? '0 : (rem_q[HGT_W-1:0] + 13'd1);
			OP_GET_W:  x_q  <= x_clip;
			OP_MUL_SLOPE: begin
				acc_q   <= sext(cfg.coef[REG_A2]);
				mcand_q <= sext(cfg.coef[REG_A0]);
				mpl_q   <= x_q;
			end
			OP_MUL_OFFS: begin
				acc_q   <= sext(cfg.coef[REG_A3]);
				mcand_q <= sext(cfg.coef[REG_A1]);
				mpl_q   <= x_q;
			end
			OP_MUL_N: begin
				acc_q   <= offs_q;
				mcand_q <= slope_q;
				mpl_q   <= y_sel;
			end
			OP_MUL_D: begin
				acc_q   <= sext(cfg.coef[REG_A5]);
				mcand_q <= sext(cfg.coef[REG_A4]);
				mpl_q   <= y_sel;
			end
			OP_PUT_SLOPE: slope_q <= acc_q;
			OP_PUT_OFFS:  offs_q  <= acc_q;
			OP_PUT_N:     n_q     <= acc_q;
			OP_PUT_D:     d_q     <= acc_q;
			OP_PUT_ROW:   row_q[cmd.sel] <= row_new;
			OP_ORDER: begin
				yeo_q  <= yeo;
				nz_q   <= nz_full[29] ? '0 : nz_full[RUN_W-1:0];
				no_q   <= no_full[HGT_W-1:0];
				skip_q <= nz_full[29] && (no_full[29] || (no_full == '0));
			end
			OP_COMMIT: begin
				prev_col_q <= x_q;
				prev_row_q <= yeo_q;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/rlrpu_ctrl.sv @@
// Sequencer of the run-length projective remap unit: steps the datapath
// through one input word and issues its result words.
// Depends on rlrpu_pkg.
module rlrpu_ctrl import rlrpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  logic     out_free,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DECIDE = 5'd1;
	localparam logic [4:0] ST_FDIV   = 5'd2;
	localparam logic [4:0] ST_FWAIT  = 5'd3;
	localparam logic [4:0] ST_FCZ    = 5'd4;
	localparam logic [4:0] ST_FEM1   = 5'd5;
	localparam logic [4:0] ST_FEM2   = 5'd6;
	localparam logic [4:0] ST_CLEAR  = 5'd7;
	localparam logic [4:0] ST_DIVR   = 5'd8;
	localparam logic [4:0] ST_WAITR  = 5'd9;
	localparam logic [4:0] ST_DIVE   = 5'd10;
	localparam logic [4:0] ST_WAITE  = 5'd11;
	localparam logic [4:0] ST_MSL    = 5'd12;
	localparam logic [4:0] ST_WSL    = 5'd13;
	localparam logic [4:0] ST_MOF    = 5'd14;
	localparam logic [4:0] ST_WOF    = 5'd15;
	localparam logic [4:0] ST_MN     = 5'd16;
	localparam logic [4:0] ST_WN     = 5'd17;
	localparam logic [4:0] ST_MD     = 5'd18;
	localparam logic [4:0] ST_WD     = 5'd19;
	localparam logic [4:0] ST_MAP    = 5'd20;
	localparam logic [4:0] ST_WMAP   = 5'd21;
	localparam logic [4:0] ST_ORDER  = 5'd22;
	localparam logic [4:0] ST_CHECK  = 5'd23;
	localparam logic [4:0] ST_EMIT   = 5'd24;
	localparam logic [4:0] ST_EM2    = 5'd25;

	logic [4:0] state_q, state_nx;
	logic       sel_q, sel_nx;
	logic       accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	// next state and datapath command
	always_comb begin
		state_nx = state_q;
		sel_nx   = sel_q;
		cmd      = '{op: OP_NOP, sel: sel_q};
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (stat.fin) begin
					cmd.op   = OP_FINPOS;
					state_nx = ST_FDIV;
				end else if (!stat.expect_ones) begin
					cmd.op   = OP_ZPOS;
					state_nx = ST_IDLE;
				end else begin
					cmd.op   = OP_ONEPOS;
					state_nx = ST_DIVR;
				end
			end
			// closing run
			ST_FDIV: begin
				cmd.op   = OP_DIV_W;
				state_nx = ST_FWAIT;
			end
			ST_FWAIT: begin
				if (!stat.busy) begin
					cmd.op   = OP_GET_W;
					state_nx = ST_FCZ;
				end
			end
			ST_FCZ: begin
				cmd.op   = OP_FIN_CZ;
				state_nx = ST_FEM1;
			end
			ST_FEM1: begin
				if (out_free) begin
					if (stat.held_zero) begin
						cmd.op   = OP_EMIT_PEND_LAST;
						state_nx = ST_CLEAR;
					end else begin
						cmd.op   = OP_EMIT_HELD_FIN;
						state_nx = stat.pend_zero ? ST_CLEAR : ST_FEM2;
					end
				end
			end
			ST_FEM2: begin
				if (out_free) begin
					cmd.op   = OP_EMIT_PEND_LAST;
					state_nx = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.op   = OP_CLEAR;
				state_nx = ST_IDLE;
			end
			// column and rows of a ones run
			ST_DIVR: begin
				cmd.op   = OP_DIV_R;
				state_nx = ST_WAITR;
			end
			ST_WAITR: begin
				if (!stat.busy) begin
					cmd.op   = OP_GET_XS;
					state_nx = ST_DIVE;
				end
			end
			ST_DIVE: begin
				cmd.op   = OP_DIV_END;
				state_nx = ST_WAITE;
			end
			ST_WAITE: begin
				if (!stat.busy) begin
					cmd.op   = OP_GET_YE;
					state_nx = ST_MSL;
				end
			end
			// per-column coefficients
			ST_MSL: begin
				cmd.op   = OP_MUL_SLOPE;
				state_nx = ST_WSL;
			end
			ST_WSL: begin
				if (!stat.busy) begin
					cmd.op   = OP_PUT_SLOPE;
					state_nx = ST_MOF;
				end
			end
			ST_MOF: begin
				cmd.op   = OP_MUL_OFFS;
				state_nx = ST_WOF;
			end
			ST_WOF: begin
				if (!stat.busy) begin
					cmd.op   = OP_PUT_OFFS;
					sel_nx   = 1'b0;
					state_nx = ST_MN;
				end
			end
			// map one row end
			ST_MN: begin
				cmd.op   = OP_MUL_N;
				state_nx = ST_WN;
			end
			ST_WN: begin
				if (!stat.busy) begin
					cmd.op   = OP_PUT_N;
					state_nx = ST_MD;
				end
			end
			ST_MD: begin
				cmd.op   = OP_MUL_D;
				state_nx = ST_WD;
			end
			ST_WD: begin
				if (!stat.busy) begin
					cmd.op   = OP_PUT_D;
					state_nx = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.op   = OP_MAP_START;
				state_nx = ST_WMAP;
			end
			ST_WMAP: begin
				if (!stat.busy) begin
					cmd.op = OP_PUT_ROW;
					if (sel_q) begin
						state_nx = ST_ORDER;
					end else begin
						sel_nx   = 1'b1;
						state_nx = ST_MN;
					end
				end
			end
			// place and emit
			ST_ORDER: begin
				cmd.op   = OP_ORDER;
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.skip) begin
					state_nx = ST_IDLE;
				end else begin
					cmd.op   = OP_COMMIT;
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				priority if (stat.no_zero) begin
					state_nx = ST_IDLE;
				end else if (stat.held_zero) begin
					if (out_free) begin
						cmd.op   = OP_EMIT_ZERO_NEW;
						state_nx = ST_IDLE;
					end
				end else if (stat.pend_zero) begin
					cmd.op   = OP_MERGE;
					state_nx = ST_IDLE;
				end else if (out_free) begin
					cmd.op   = OP_EMIT_HELD;
					state_nx = ST_EM2;
				end
			end
			ST_EM2: begin
				if (out_free) begin
					cmd.op   = OP_EMIT_ZERO_NEW;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			sel_q   <= sel_nx;
		end
	end

	// a word is only issued when the output register can take it
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT_ZERO_NEW || cmd.op == OP_EMIT_HELD ||
		 cmd.op == OP_EMIT_HELD_FIN || cmd.op == OP_EMIT_PEND_LAST) |-> out_free)
		else $error("result word issued while output register is full");

	// no unit is reloaded while it still runs
	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MUL_SLOPE || cmd.op == OP_MUL_OFFS || cmd.op == OP_MUL_N ||
		 cmd.op == OP_MUL_D || cmd.op == OP_DIV_R || cmd.op == OP_DIV_END ||
		 cmd.op == OP_DIV_W || cmd.op == OP_MAP_START) |-> !stat.busy)
		else $error("arithmetic unit reloaded while busy");

	// an accepted word is classified in the following cycle
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DECIDE))
		else $error("accepted word not decoded");

endmodule

@@ test/rle_run_projective_remap_unit_tb.sv @@
// Self-checking testbench of the run-length projective remap unit.
// Drives masks as run words, predicts the output runs in place and checks them field by field.
// Depends on rlrpu_pkg and rle_run_projective_remap_unit.
module rle_run_projective_remap_unit_tb;
	import rlrpu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ONE = 64'h1_0000_0000;
	localparam longint RUN_TOP = 33554431;
	localparam longint HELD_TOP = 64'd1099511627776;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        item_valid = 0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 0;
	result_t     result;

	rle_run_projective_remap_unit uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// shadow registers and remap state
	logic [63:0] sh_coef [6];
	logic [12:0] sh_src_h, sh_out_h;
	longint      run_pos, prev_col, prev_row, pend_zeros, held_ones;
	bit          want_ones;
	logic signed [127:0] col_slope, col_offs;

	item_t   word_q [$];
	result_t run_q [$];
	int      fails = 0;
	int      send_idle = 0;
	int      recv_stall = 0;

	function automatic longint eff_height(logic [12:0] v);
		if (v == 0) return 1;
		return (v > 4096) ? 4096 : v;
	endfunction

	function automatic logic signed [127:0] sext(logic [63:0] v);
		return {{64{v[63]}}, v};
	endfunction

	function automatic void push_run(longint len, bit val, bit last);
		result_t r;
		if (len < 0) len = 0;
		if (len > RUN_TOP) len = RUN_TOP;
		r.out_run = len[24:0];
		r.run_value = val;
		r.last_run = last;
		run_q.push_back(r);
	endfunction

	function automatic void clear_remap();
		run_pos = 0;
		want_ones = 0;
		prev_col = -1;
		prev_row = 0;
		col_slope = 0;
		col_offs = 0;
		pend_zeros = 0;
		held_ones = 0;
	endfunction

	// map one source row through (S*y+T)/(a4*y+a5), round half away, clip
	function automatic longint map_row(longint y, longint oh);
		logic signed [127:0] yy, n, d, mn, md, q;
		yy = y;
		n = col_slope * yy + col_offs;
		d = sext(sh_coef[4]) * yy + sext(sh_coef[5]);
		if (d == 0) return (n > 0) ? oh : 0;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = (2 * mn + md) / (2 * md);
		if (q == 0 || ((n < 0) != (d < 0))) return 0;
		if (q > oh) return oh;
		return longint'(q);
	endfunction

	function automatic longint add_cap(longint a, longint b);
		return (a + b > HELD_TOP) ? HELD_TOP : a + b;
	endfunction

	// advance the remap state by one word and queue the runs it yields
	function automatic void remap_word(item_t w);
		longint h, oh, prow, len, r, x, ys, ye, fin_end, yso, yeo, nz, no, t, wd, cz;
		logic signed [127:0] xx;
		h = eff_height(sh_src_h);
		oh = eff_height(sh_out_h);
		prow = (prev_col < 0) ? oh : prev_row;
		len = w.run_length;
		if (w.final_item) begin
			run_pos = (run_pos + len > RUN_TOP) ? RUN_TOP : run_pos + len;
			wd = run_pos / h;
			if (wd > 4096) wd = 4096;
			cz = oh * (wd - prev_col) - prow;
			if (cz < 0) cz = 0;
			pend_zeros = add_cap(pend_zeros, cz);
			if (held_ones > 0) begin
				push_run(held_ones, 1, pend_zeros == 0);
				if (pend_zeros > 0) push_run(pend_zeros, 0, 1);
			end else begin
				push_run(pend_zeros, 0, 1);
			end
			clear_remap();
			return;
		end
		if (!want_ones) begin
			run_pos = (run_pos + len > RUN_TOP) ? RUN_TOP : run_pos + len;
			want_ones = 1;
			return;
		end
		want_ones = 0;
		r = run_pos;
		run_pos = (r + len > RUN_TOP) ? RUN_TOP : r + len;
		x = r / h;
		if (x > 4096) x = 4096;
		ys = r % h;
		fin_end = r + len;
		ye = (fin_end == 0) ? 0 : (fin_end - 1) % h + 1;
		xx = x;
		col_slope = sext(sh_coef[0]) * xx + sext(sh_coef[2]);
		col_offs = sext(sh_coef[1]) * xx + sext(sh_coef[3]);
		yso = map_row(ys, oh);
		yeo = map_row(ye, oh);
		if (yso > yeo) begin
			t = yso;
			yso = yeo;
			yeo = t;
		end
		nz = oh * (x - prev_col) + yso - prow;
		no = yeo - yso;
		// shorten or skip a run that would move backwards
		if (nz < 0) begin
			no += nz;
			if (no <= 0) return;
			nz = 0;
		end
		prev_row = yeo;
		prev_col = x;
		pend_zeros = add_cap(pend_zeros, nz);
		if (no == 0) return;
		if (held_ones == 0) begin
			push_run(pend_zeros, 0, 0);
			held_ones = no;
			pend_zeros = 0;
			return;
		end
		if (pend_zeros == 0) begin
			held_ones = add_cap(held_ones, no);
			return;
		end
		push_run(held_ones, 1, 0);
		push_run(pend_zeros, 0, 0);
		held_ones = no;
		pend_zeros = 0;
	endfunction

	// driver: hold a stalled word, advance on acceptance, idle at random
	always @(posedge clk) begin
		logic  nv;
		item_t nw;
		if (arst_n) begin
			nv = item_valid;
			nw = item;
			if (item_valid && !item_stall) begin
				remap_word(item);
				void'(word_q.pop_front());
				nv = 0;
			end
			if (!nv && word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				nv = 1;
				nw = word_q[0];
			end
			item_valid <= nv;
			item <= nw;
		end
	end

	// monitor: check each accepted run against the oldest prediction
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (run_q.size() == 0) begin
					$error("unexpected run word: out_run %0d run_value %0d last_run %0d",
						result.out_run, result.run_value, result.last_run);
					fails++;
				end else begin
					e = run_q.pop_front();
					if (result.out_run !== e.out_run) begin
						$error("out_run: expected %0d, got %0d", e.out_run, result.out_run);
						fails++;
					end
					if (result.run_value !== e.run_value) begin
						$error("run_value: expected %0d, got %0d", e.run_value,
							result.run_value);
						fails++;
					end
					if (result.last_run !== e.last_run) begin
						$error("last_run: expected %0d, got %0d", e.last_run, result.last_run);
						fails++;
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_SRC_H) sh_src_h = v[12:0];
		else if (idx == REG_OUT_H) sh_out_h = v[12:0];
		else sh_coef[idx] = v;
	endtask

	task automatic load_regs(logic [63:0] a0, a1, a2, a3, a4, a5, logic [12:0] sh, oh);
		reg_write(REG_A0, a0);
		reg_write(REG_A1, a1);
		reg_write(REG_A2, a2);
		reg_write(REG_A3, a3);
		reg_write(REG_A4, a4);
		reg_write(REG_A5, a5);
		reg_write(REG_SRC_H, {51'd0, sh});
		reg_write(REG_OUT_H, {51'd0, oh});
	endtask

	task automatic add_word(int len, bit fin);
		item_t w;
		w.run_length = 25'(len);
		w.final_item = fin;
		word_q.push_back(w);
	endtask

	// one mask of random runs; the closing word may fall on either phase
	task automatic add_mask(int h);
		int n, len;
		n = $urandom_range(20, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(29))
				0:       len = 0;
				1:       len = $urandom_range(1 << 24);
				2, 3:    len = $urandom_range(8 * h);
				default: len = $urandom_range(2 * h);
			endcase
			add_word(len, i == n - 1);
		end
	endtask

	// wait until the block has drained, then let a ones word finish
	task automatic settle();
		wait (word_q.size() == 0 && !item_valid && run_q.size() == 0);
		repeat (600) @(posedge clk);
	endtask

	initial begin
		int got;
		sh_coef = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, ONE};
		sh_src_h = 1;
		sh_out_h = 1;
		clear_remap();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		for (int ph = 0; ph < 8; ph++) begin
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 29 : 45) : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 29 : 45) : 0;
			case (ph)
				0: load_regs(0, 0, ONE, 0, 0, ONE, 8, 8);
				1: load_regs(0, -ONE, 2 * ONE, ONE >> 1, 0, ONE, 8, 16);
				2: load_regs(ONE >> 2, 0, -ONE, 5 * ONE, 0, ONE, 5, 5);
				3: load_regs(0, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, 0, 0, 1, 1);
				4: load_regs(0, 0, ONE, 0, 0, ONE, 4096, 4096);
				5: load_regs(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
					64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
					64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 3, 4096);
				6: load_regs({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, $urandom_range(32, 1), $urandom_range(32, 1));
				default: load_regs(0, ONE >> 3, 2 * ONE, 0, ONE >> 4, ONE, 16, 12);
			endcase
			if (ph == 0) begin
				// empty leading zeros, empty ones, merged ones, closing on a ones word
				add_word(0, 0); add_word(3, 0); add_word(2, 0); add_word(0, 0);
				add_word(5, 0); add_word(4, 0); add_word(0, 0); add_word(2, 0);
				add_word(9, 0); add_word(1, 0); add_word(7, 1);
				add_word(4, 0); add_word(1 << 24, 0); add_word(3, 0); add_word(5, 1);
				add_word(0, 1);
				add_word(25'h1FF_FFFF, 0); add_word(25'h0AA_AAAA, 0); add_word(0, 1);
				add_word(25'h155_5555, 1);
			end
			got = 0;
			while (got < 45) begin
				add_mask(int'(eff_height(sh_src_h)));
				got = word_q.size();
			end
			settle();
		end
		if (fails == 0) $display("rle_run_projective_remap_unit regression: pass");
		else $display("rle_run_projective_remap_unit regression: fail");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#20ms;
		$display("rle_run_projective_remap_unit regression: fail");
		$finish;
	end

endmodule
